[design/obpl_pkg.sv]
package obpl_pkg;

   // Field widths of one request and one result.
   localparam int PRICE_W  = 32;
   localparam int QTY_W    = 31;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Default depth of each side of the book.
   localparam int LEVELS_DEFAULT = 64;

   typedef enum logic [OP_W-1:0] {
      OP_INS_BID = 2'd0,
      OP_INS_ASK = 2'd1,
      OP_DEL_BID = 2'd2,
      OP_DEL_ASK = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // Command broadcast from the top level to one side of the book.
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } side_cmd_type;

   // Qualified command broadcast along the row of cells.
   typedef struct packed {
      logic              do_ins;
      logic              do_del;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cell_ctl_type;

   // What one side reports back for the result of the current request.
   typedef struct packed {
      logic              full;
      logic              found;
      logic [PRICE_W-1:0] best_price;
      logic [QTY_W-1:0]   best_qty;
   } side_view_type;

endpackage

[design/obpl_if.sv]
interface obpl_req_if import obpl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [PRICE_W-1:0] price;
   logic [QTY_W-1:0]   quantity;

   modport source (output valid, output opcode, output price, output quantity, input ready);
   modport sink   (input valid, input opcode, input price, input quantity, output ready);
endinterface

interface obpl_rsp_if import obpl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PRICE_W-1:0]  best_bid_price;
   logic [QTY_W-1:0]    best_bid_quantity;
   logic [PRICE_W-1:0]  best_ask_price;
   logic [QTY_W-1:0]    best_ask_quantity;
   logic [COUNT_W-1:0]  bid_levels_used;
   logic [COUNT_W-1:0]  ask_levels_used;

   modport source (output valid, output status, output best_bid_price,
                   output best_bid_quantity, output best_ask_price,
                   output best_ask_quantity, output bid_levels_used,
                   output ask_levels_used, input ready);
   modport sink   (input valid, input status, input best_bid_price,
                   input best_bid_quantity, input best_ask_price,
                   input best_ask_quantity, input bid_levels_used,
                   input ask_levels_used, output ready);
endinterface

[design/obpl_cell.sv]
module obpl_cell import obpl_pkg::*; #(
   parameter bit DESCENDING = 1'b1
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               valid,
   input  logic               left_ins,
   input  logic [PRICE_W-1:0] left_price,
   input  logic [QTY_W-1:0]   left_qty,
   input  logic [PRICE_W-1:0] right_price,
   input  logic [QTY_W-1:0]   right_qty,
   output logic               ins,
   output logic               match,
   output logic [PRICE_W-1:0] price_in,
   output logic [QTY_W-1:0]   qty_in,
   output logic [PRICE_W-1:0] price,
   output logic [QTY_W-1:0]   qty
);

   logic [PRICE_W-1:0] price_ff;
   logic [QTY_W-1:0]   qty_ff;
   logic               beyond;
   logic               equal;
   logic               at_or_after;

   // Local compare against the broadcast price. As the row is sorted, the
   // insert flag is false up to the insert position and true from there on.
   assign beyond      = DESCENDING ? (price_ff < ctl.price) : (price_ff > ctl.price);
   assign equal       = (price_ff == ctl.price);
   assign ins         = !valid || beyond;
   assign match       = valid && equal;
   assign at_or_after = !valid || beyond || equal;

   // The cell at the insert position takes the new level, those after it
   // take their left neighbour; on a delete the matching cell and all after
   // it take their right neighbour.
   always_comb begin
      priority if (ctl.do_ins && ins && !left_ins) begin
         price_in = ctl.price;
         qty_in   = ctl.qty;
      end else if (ctl.do_ins && ins) begin
         price_in = left_price;
         qty_in   = left_qty;
      end else if (ctl.do_del && at_or_after) begin
         price_in = right_price;
         qty_in   = right_qty;
      end else begin
         price_in = price_ff;
         qty_in   = qty_ff;
      end
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   assign price = price_ff;
   assign qty   = qty_ff;

endmodule

[design/obpl_side.sv]
module obpl_side import obpl_pkg::*; #(
   parameter int LEVELS     = LEVELS_DEFAULT,
   parameter bit DESCENDING = 1'b1,
   localparam int CW        = $clog2(LEVELS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  side_cmd_type  cmd,
   output side_view_type view,
   output logic [CW-1:0] count,
   output logic [CW-1:0] count_in
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(LEVELS);

   logic [CW-1:0]      count_ff;
   cell_ctl_type       ctl;
   logic [LEVELS-1:0]  valid;
   logic [LEVELS-1:0]  ins;
   logic [LEVELS-1:0]  match;
   logic [PRICE_W-1:0] price   [LEVELS];
   logic [QTY_W-1:0]   qty     [LEVELS];
   logic [PRICE_W-1:0] price_n [LEVELS];
   logic [QTY_W-1:0]   qty_n   [LEVELS];

   // Qualify the command: a full table drops inserts, a missing price
   // leaves the table alone.
   assign view.full  = (count_ff == FULL_COUNT);
   assign view.found = |match;
   assign ctl.do_ins = cmd.ins && !view.full;
   assign ctl.do_del = cmd.del && view.found;
   assign ctl.price  = cmd.price;
   assign ctl.qty    = cmd.qty;

   // The row of cells, each linked to both neighbours.
   for (genvar k = 0; k < LEVELS; k++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(k);
      logic               l_ins;
      logic [PRICE_W-1:0] l_price;
      logic [QTY_W-1:0]   l_qty;
      logic [PRICE_W-1:0] r_price;
      logic [QTY_W-1:0]   r_qty;

      assign valid[k] = (IDX < count_ff);

      if (k == 0) begin : g_first
         assign l_ins   = 1'b0;
         assign l_price = '0;
         assign l_qty   = '0;
      end else begin : g_mid
         assign l_ins   = ins[k-1];
         assign l_price = price[k-1];
         assign l_qty   = qty[k-1];
      end

      if (k == LEVELS - 1) begin : g_last
         assign r_price = '0;
         assign r_qty   = '0;
      end else begin : g_inner
         assign r_price = price[k+1];
         assign r_qty   = qty[k+1];
      end

      obpl_cell #(.DESCENDING(DESCENDING)) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .valid       (valid[k]),
         .left_ins    (l_ins),
         .left_price  (l_price),
         .left_qty    (l_qty),
         .right_price (r_price),
         .right_qty   (r_qty),
         .ins         (ins[k]),
         .match       (match[k]),
         .price_in    (price_n[k]),
         .qty_in      (qty_n[k]),
         .price       (price[k]),
         .qty         (qty[k])
      );
   end

   // Level count follows the qualified command.
   always_comb begin
      priority if (ctl.do_ins) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.do_del) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Best level after this request is what the first cell loads.
   assign view.best_price = (count_in == '0) ? '0 : price_n[0];
   assign view.best_qty   = (count_in == '0) ? '0 : qty_n[0];
   assign count           = count_ff;

endmodule

[design/order_book_price_level_table_top.sv]
// Price level table of a limit order book, one bid side and one ask side.
// Requests arrive on req_chan (valid/ready): an opcode to insert a bid or an
// ask level, or to delete the first bid or ask level of an exact price, with
// the price in ticks and the quantity of the level.
// Each request gives exactly one response on rsp_chan: a status (done, table
// full, price not found), the best bid and best ask with their quantities
// (zero for an empty side) and the levels held on each side afterwards.
// Each side is a row of cells, one level per cell, kept sorted best first;
// all cells compare against the request price in the same cycle and shift
// towards their neighbours. The response is registered at the edge that
// accepts the request. Throughput is one request per cycle while the
// receiver takes responses. When the receiver stalls, the pending response
// holds and req_chan.ready is low until it is taken.
// Reset empties both tables and drops any pending response; there is no
// clearing pass, the block takes requests in the first cycle after reset.
module order_book_price_level_table_top import obpl_pkg::*; #(
   parameter int LEVELS = LEVELS_DEFAULT,
   localparam int CW    = $clog2(LEVELS + 1)
) (
   input logic         clock,
   input logic         reset,
   obpl_req_if.sink    req_chan,
   obpl_rsp_if.source  rsp_chan
);

   localparam logic [CW-1:0] FULL_COUNT = CW'(LEVELS);

   logic               req_fire;
   opcode_type         opcode;
   side_cmd_type       bid_cmd;
   side_cmd_type       ask_cmd;
   side_view_type      bid_view;
   side_view_type      ask_view;
   logic [CW-1:0]      bid_count;
   logic [CW-1:0]      ask_count;
   logic [CW-1:0]      bid_count_in;
   logic [CW-1:0]      ask_count_in;
   status_type         status_in;

   logic               rsp_valid_ff;
   status_type         status_ff;
   logic [PRICE_W-1:0] bid_price_ff;
   logic [QTY_W-1:0]   bid_qty_ff;
   logic [PRICE_W-1:0] ask_price_ff;
   logic [QTY_W-1:0]   ask_qty_ff;
   logic [COUNT_W-1:0] bid_used_ff;
   logic [COUNT_W-1:0] ask_used_ff;

   // A new request is taken whenever the response register is free or
   // being emptied in this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign opcode         = opcode_type'(req_chan.opcode);

   // Steer the request to one side.
   assign bid_cmd.ins   = req_fire && (opcode == OP_INS_BID);
   assign bid_cmd.del   = req_fire && (opcode == OP_DEL_BID);
   assign bid_cmd.price = req_chan.price;
   assign bid_cmd.qty   = req_chan.quantity;
   assign ask_cmd.ins   = req_fire && (opcode == OP_INS_ASK);
   assign ask_cmd.del   = req_fire && (opcode == OP_DEL_ASK);
   assign ask_cmd.price = req_chan.price;
   assign ask_cmd.qty   = req_chan.quantity;

   obpl_side #(.LEVELS(LEVELS), .DESCENDING(1'b1)) u_bid (
      .clock    (clock),
      .reset    (reset),
      .cmd      (bid_cmd),
      .view     (bid_view),
      .count    (bid_count),
      .count_in (bid_count_in)
   );

   obpl_side #(.LEVELS(LEVELS), .DESCENDING(1'b0)) u_ask (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ask_cmd),
      .view     (ask_view),
      .count    (ask_count),
      .count_in (ask_count_in)
   );

   // Status of the request being accepted.
   always_comb begin
      unique case (opcode)
         OP_INS_BID: status_in = bid_view.full   ? ST_FULL      : ST_DONE;
         OP_INS_ASK: status_in = ask_view.full   ? ST_FULL      : ST_DONE;
         OP_DEL_BID: status_in = bid_view.found  ? ST_DONE      : ST_NOT_FOUND;
         OP_DEL_ASK: status_in = ask_view.found  ? ST_DONE      : ST_NOT_FOUND;
         default:    status_in = ST_DONE;
      endcase
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff    <= status_in;
         bid_price_ff <= bid_view.best_price;
         bid_qty_ff   <= bid_view.best_qty;
         ask_price_ff <= ask_view.best_price;
         ask_qty_ff   <= ask_view.best_qty;
         bid_used_ff  <= COUNT_W'(bid_count_in);
         ask_used_ff  <= COUNT_W'(ask_count_in);
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.best_bid_price    = bid_price_ff;
   assign rsp_chan.best_bid_quantity = bid_qty_ff;
   assign rsp_chan.best_ask_price    = ask_price_ff;
   assign rsp_chan.best_ask_quantity = ask_qty_ff;
   assign rsp_chan.bid_levels_used   = bid_used_ff;
   assign rsp_chan.ask_levels_used   = ask_used_ff;

   // Neither table ever holds more levels than it has cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (bid_count <= FULL_COUNT) && (ask_count <= FULL_COUNT))
      else $error("level count beyond table depth");

   // An accepted bid insert into a table with room adds exactly one level.
   a_bid_insert: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (opcode == OP_INS_BID) && (bid_count != FULL_COUNT))
      |=> (bid_count == $past(bid_count) + CW'(1)))
      else $error("bid insert did not add one level");

   // A delete from an empty ask table reports not found and changes nothing.
   a_ask_empty_del: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (opcode == OP_DEL_ASK) && (ask_count == '0))
      |=> (status_ff == ST_NOT_FOUND) && (ask_count == '0))
      else $error("delete from empty ask table not reported");

   // A full bid table drops the insert and keeps its count.
   a_bid_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (opcode == OP_INS_BID) && (bid_count == FULL_COUNT))
      |=> (status_ff == ST_FULL) && (bid_count == FULL_COUNT))
      else $error("insert into full bid table not dropped");

endmodule

[dv/order_book_price_level_table_top_test.sv]
`timescale 1ns / 100ps

module order_book_price_level_table_top_test;
   import obpl_pkg::*;

   localparam int BOOK_LEVELS      = LEVELS_DEFAULT;
   localparam int SIDE_BID         = 0;
   localparam int SIDE_ASK         = 1;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;
   localparam int PRICE_CENTRE     = 1000000;

   // Top of book and occupancy as reported for one request.
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [PRICE_W-1:0]  bid_price;
      logic [QTY_W-1:0]    bid_qty;
      logic [PRICE_W-1:0]  ask_price;
      logic [QTY_W-1:0]    ask_qty;
      logic [COUNT_W-1:0]  bid_used;
      logic [COUNT_W-1:0]  ask_used;
   } book_top_type;

   logic clock = 1'b0;
   logic reset;

   obpl_req_if req_chan ();
   obpl_rsp_if rsp_chan ();

   order_book_price_level_table_top #(.LEVELS(BOOK_LEVELS)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of both sides of the book, best level first.
   logic [PRICE_W-1:0] level_price [2][BOOK_LEVELS];
   logic [QTY_W-1:0]   level_qty   [2][BOOK_LEVELS];
   int                 level_count [2];

   book_top_type pending_book_tops [$];
   int        error_count    = 0;
   int        response_count = 0;
   int        cycle_count    = 0;
   bit        sender_idling  = 1'b1;
   bit        receiver_idling = 1'b1;
   bit        long_hold_request = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Insert a level after every level of equal or better price.
   function automatic status_type insert_level(int side, logic [PRICE_W-1:0] price,
                                               logic [QTY_W-1:0] qty);
      int k;
      int pos;
      bit placed;
      if (level_count[side] >= BOOK_LEVELS)
         return ST_FULL;
      pos = level_count[side];
      placed = 1'b0;
      for (k = 0; k < level_count[side]; k++) begin
         if (!placed && (side == SIDE_BID ? level_price[side][k] < price
                                          : level_price[side][k] > price)) begin
            placed = 1'b1;
            pos = k;
         end
      end
      for (k = level_count[side]; k > pos; k--) begin
         level_price[side][k] = level_price[side][k-1];
         level_qty[side][k]   = level_qty[side][k-1];
      end
      level_price[side][pos] = price;
      level_qty[side][pos]   = qty;
      level_count[side]++;
      return ST_DONE;
   endfunction

   // Remove the first level, best first, whose price matches exactly.
   function automatic status_type remove_level(int side, logic [PRICE_W-1:0] price);
      int k;
      int pos;
      bit hit;
      hit = 1'b0;
      pos = 0;
      for (k = 0; k < level_count[side]; k++) begin
         if (!hit && level_price[side][k] == price) begin
            hit = 1'b1;
            pos = k;
         end
      end
      if (!hit)
         return ST_NOT_FOUND;
      for (k = pos; k + 1 < level_count[side]; k++) begin
         level_price[side][k] = level_price[side][k+1];
         level_qty[side][k]   = level_qty[side][k+1];
      end
      level_count[side]--;
      return ST_DONE;
   endfunction

   // Apply one accepted request to the mirror and queue the top of book it gives.
   function automatic void book_apply(opcode_type op, logic [PRICE_W-1:0] price,
                                      logic [QTY_W-1:0] qty);
      book_top_type top;
      case (op)
         OP_INS_BID: top.status = insert_level(SIDE_BID, price, qty);
         OP_INS_ASK: top.status = insert_level(SIDE_ASK, price, qty);
         OP_DEL_BID: top.status = remove_level(SIDE_BID, price);
         default:    top.status = remove_level(SIDE_ASK, price);
      endcase
      top.bid_price = level_count[SIDE_BID] != 0 ? level_price[SIDE_BID][0] : '0;
      top.bid_qty   = level_count[SIDE_BID] != 0 ? level_qty[SIDE_BID][0]   : '0;
      top.ask_price = level_count[SIDE_ASK] != 0 ? level_price[SIDE_ASK][0] : '0;
      top.ask_qty   = level_count[SIDE_ASK] != 0 ? level_qty[SIDE_ASK][0]   : '0;
      top.bid_used  = COUNT_W'(level_count[SIDE_BID]);
      top.ask_used  = COUNT_W'(level_count[SIDE_ASK]);
      pending_book_tops.push_back(top);
   endfunction

   function automatic string format_top(book_top_type top);
      return $sformatf("status=%0d bid=%h/%h ask=%h/%h used=%0d/%0d", top.status,
                       top.bid_price, top.bid_qty, top.ask_price, top.ask_qty,
                       top.bid_used, top.ask_used);
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("%s", msg);
   endfunction

   // Prices mostly come from a narrow band so that deletes hit and levels tie.
   function automatic logic [PRICE_W-1:0] rand_price();
      case ($urandom_range(0, 9))
         7:       return $urandom;
         8:       return '0;
         9:       return '1;
         default: return PRICE_W'(PRICE_CENTRE + $urandom_range(0, 40));
      endcase
   endfunction

   function automatic logic [QTY_W-1:0] rand_qty();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return QTY_W'($urandom);
         default: return QTY_W'($urandom_range(1, 1000));
      endcase
   endfunction

   // Mostly the price of a level that is held, otherwise any price.
   function automatic logic [PRICE_W-1:0] pick_price(int side);
      if (level_count[side] != 0 && $urandom_range(0, 3) != 0)
         return level_price[side][$urandom_range(0, level_count[side] - 1)];
      return rand_price();
   endfunction

   // Offer one request, with an optional idle burst first, and wait for it to be taken.
   task automatic send_request(opcode_type op, logic [PRICE_W-1:0] price,
                               logic [QTY_W-1:0] qty);
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.opcode   <= op;
      req_chan.price    <= price;
      req_chan.quantity <= qty;
      @(posedge clock);
      while (req_chan.ready !== 1'b1)
         @(posedge clock);
      book_apply(op, price, qty);
   endtask

   task automatic send_random_request(int insert_pct);
      opcode_type op;
      bit ask_side;
      ask_side = 1'($urandom_range(0, 1));
      if ($urandom_range(1, 100) <= insert_pct) begin
         op = ask_side ? OP_INS_ASK : OP_INS_BID;
         send_request(op, rand_price(), rand_qty());
      end else begin
         op = ask_side ? OP_DEL_ASK : OP_DEL_BID;
         send_request(op, pick_price(ask_side ? SIDE_ASK : SIDE_BID), rand_qty());
      end
   endtask

   // Receiver: random stall bursts, and one long hold-off when asked.
   initial begin : response_ready_driver
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each response taken with the oldest expected top of book.
   initial begin : response_checker
      book_top_type got;
      book_top_type want;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.status    = rsp_chan.status;
            got.bid_price = rsp_chan.best_bid_price;
            got.bid_qty   = rsp_chan.best_bid_quantity;
            got.ask_price = rsp_chan.best_ask_price;
            got.ask_qty   = rsp_chan.best_ask_quantity;
            got.bid_used  = rsp_chan.bid_levels_used;
            got.ask_used  = rsp_chan.ask_levels_used;
            if (pending_book_tops.size() == 0) begin
               flag_error($sformatf("response %0d with no request waiting: %s",
                                    response_count, format_top(got)));
            end else begin
               want = pending_book_tops.pop_front();
               if (got.status !== want.status || got.bid_price !== want.bid_price ||
                   got.bid_qty !== want.bid_qty || got.ask_price !== want.ask_price ||
                   got.ask_qty !== want.ask_qty || got.bid_used !== want.bid_used ||
                   got.ask_used !== want.ask_used)
                  flag_error($sformatf("response %0d mismatch: expected %s, actual %s",
                                       response_count, format_top(want), format_top(got)));
            end
            response_count++;
         end
      end
   end

   // Empty sides, extreme prices and quantities, and ties on price.
   task automatic test_directed_cases();
      send_request(OP_DEL_BID, '0, '0);
      send_request(OP_DEL_ASK, '1, '1);
      send_request(OP_INS_BID, 32'd100, '0);
      send_request(OP_INS_BID, 32'd100, 31'd7);
      send_request(OP_INS_BID, '1, '1);
      send_request(OP_INS_BID, '0, 31'd1);
      send_request(OP_DEL_BID, '1, 31'h2AAA_AAAA);
      send_request(OP_DEL_BID, 32'd100, 31'h5555_5555);
      send_request(OP_DEL_BID, 32'd55, '0);
      send_request(OP_INS_ASK, '1, 31'd5);
      send_request(OP_INS_ASK, '0, '1);
      send_request(OP_INS_ASK, '0, 31'd3);
      send_request(OP_INS_ASK, 32'hAAAA_AAAA, 31'h2AAA_AAAA);
      send_request(OP_INS_BID, 32'h5555_5555, 31'h5555_5555);
      send_request(OP_DEL_ASK, '0, '0);
      send_request(OP_DEL_ASK, '0, '0);
      send_request(OP_DEL_ASK, 32'd12345, '0);
      send_request(OP_DEL_ASK, 32'hAAAA_AAAA, '0);
      send_request(OP_DEL_ASK, '1, '0);
      send_request(OP_DEL_BID, 32'h5555_5555, '0);
      send_request(OP_DEL_BID, 32'd100, '0);
      send_request(OP_DEL_BID, '0, '0);
      send_request(OP_DEL_ASK, '0, '0);
   endtask

   // Fill both sides past capacity, then drain them again.
   task automatic test_fill_both_sides();
      int k;
      for (k = 0; k < BOOK_LEVELS + 3; k++)
         send_request(OP_INS_BID, rand_price(), rand_qty());
      for (k = 0; k < BOOK_LEVELS + 3; k++)
         send_request(OP_INS_ASK, rand_price(), rand_qty());
      send_request(OP_INS_BID, '1, '1);
      send_request(OP_INS_ASK, '0, '1);
      while (level_count[SIDE_BID] + level_count[SIDE_ASK] > 0) begin
         if ($urandom_range(0, 1))
            send_request(OP_DEL_BID, pick_price(SIDE_BID), rand_qty());
         else
            send_request(OP_DEL_ASK, pick_price(SIDE_ASK), rand_qty());
      end
   endtask

   // Long receiver hold-off while requests keep coming, so the input stalls.
   task automatic test_response_backpressure();
      int k;
      sender_idling = 1'b0;
      long_hold_request = 1'b1;
      for (k = 0; k < 30; k++)
         send_random_request(60);
      sender_idling = 1'b1;
   endtask

   // Random traffic, with the insert share moving the book between empty and full.
   task automatic test_random_mix();
      int k;
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      for (k = 0; k < 400; k++)
         send_random_request(60);
      sender_idling = 1'b0;
      for (k = 0; k < 300; k++)
         send_random_request(75);
      sender_idling = 1'b1;
      receiver_idling = 1'b0;
      for (k = 0; k < 300; k++)
         send_random_request(35);
      receiver_idling = 1'b1;
      for (k = 0; k < 350; k++)
         send_random_request(50);
   endtask

   // One request per cycle with both sides always ready.
   task automatic test_back_to_back();
      int k;
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      for (k = 0; k < 100; k++)
         send_random_request(55);
   endtask

   initial begin : test_sequence
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.opcode   = OP_INS_BID;
      req_chan.price    = '0;
      req_chan.quantity = '0;
      level_count[SIDE_BID] = 0;
      level_count[SIDE_ASK] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fill_both_sides();
      test_response_backpressure();
      test_random_mix();
      test_back_to_back();

      // Let the last responses drain, then watch for strays.
      req_chan.valid <= 1'b0;
      while (pending_book_tops.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_book_tops.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[files.f]
design/obpl_pkg.sv
design/obpl_if.sv
design/obpl_cell.sv
design/obpl_side.sv
design/order_book_price_level_table_top.sv
dv/order_book_price_level_table_top_test.sv
